// ===== src/dqls_pkg.sv =====
// Shared types and constants for the deque with linear search.
// Used by dqls_ctrl, dqls_datapath and deque_with_linear_search_core.
`default_nettype none
package dqls_pkg;

  localparam int DEPTH_DEF = 64;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_SEARCH     = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int FUNC_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 24;

  typedef struct packed {
    logic start;
    logic step;
    logic load_out;
  } dqls_cmd_t;

  typedef struct packed {
    logic empty;
    logic hit;
    logic last;
  } dqls_stat_t;

endpackage
`default_nettype wire

// ===== src/dqls_ctrl.sv =====
// Controller for the deque: accept, search walk and output handoff.
// Depends on dqls_pkg.
`default_nettype none
module dqls_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [dqls_pkg::FUNC_W-1:0] func,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  input  wire dqls_pkg::dqls_stat_t      stat,
  output dqls_pkg::dqls_cmd_t            cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SRCH = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       accept;
  logic [1:0] after_accept;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE) || ((state_r == S_DONE) && out_free);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  assign after_accept = ((func == dqls_pkg::OP_SEARCH) && !stat.empty) ? S_SRCH : S_DONE;

  always_comb begin
    cmd.start    = accept;
    cmd.step     = (state_r == S_SRCH);
    cmd.load_out = (state_r == S_DONE) && out_free;
    state_nxt    = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = after_accept;
      end
      S_SRCH: begin
        if (stat.hit || stat.last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = accept ? after_accept : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/dqls_datapath.sv =====
// Datapath for the deque: ring store, front pointer, count, search walk,
// result and output registers. Depends on dqls_pkg.
`default_nettype none
module dqls_datapath #(
  parameter int DEPTH = dqls_pkg::DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire dqls_pkg::dqls_cmd_t              cmd,
  input  wire logic [dqls_pkg::FUNC_W-1:0]      func,
  input  wire logic [dqls_pkg::VALUE_W-1:0]     item_value,
  input  wire logic [dqls_pkg::VALUE_W-1:0]     search_key,
  output dqls_pkg::dqls_stat_t                  stat,
  output logic [dqls_pkg::OUT_DATA_W-1:0]       out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW:0]   DEPTH_S   = (CW + 1)'(DEPTH);
  localparam int VALUE_W_L = dqls_pkg::VALUE_W;

  logic [VALUE_W_L-1:0] mem [DEPTH];

  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] next_addr_r;
  logic [AW-1:0] cmp_off_r;
  logic [VALUE_W_L-1:0] rdata_r;
  logic [VALUE_W_L-1:0] key_r;

  logic [1:0]    res_status_r;
  logic          res_found_r;
  logic [AW-1:0] res_pos_r;

  logic [AW-1:0] front_inc, front_dec, next_inc, back_slot, rd_addr;
  logic [CW:0]   back_sum;
  logic          full, empty;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [1:0]    start_status;
  logic [31:0]   pos_ext, cnt_ext;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  assign front_inc = (front_r == LAST_SLOT) ? '0 : front_r + AW'(1);
  assign front_dec = (front_r == '0) ? LAST_SLOT : front_r - AW'(1);
  assign next_inc  = (next_addr_r == LAST_SLOT) ? '0 : next_addr_r + AW'(1);
  assign back_sum  = (CW + 1)'(front_r) + (CW + 1)'(count_r);
  assign back_slot = (back_sum >= DEPTH_S) ? AW'(back_sum - DEPTH_S) : AW'(back_sum);

  assign stat.empty = empty;
  assign stat.hit   = (rdata_r == key_r);
  assign stat.last  = (CW'(cmp_off_r) == count_r - CW'(1));

  always_comb begin
    front_nxt    = front_r;
    count_nxt    = count_r;
    wr_en        = 1'b0;
    wr_addr      = back_slot;
    start_status = dqls_pkg::ST_DONE;
    case (func)
      dqls_pkg::OP_PUSH_FRONT: begin
        if (full) start_status = dqls_pkg::ST_FULL;
        else begin
          front_nxt = front_dec;
          count_nxt = count_r + CW'(1);
          wr_en     = 1'b1;
          wr_addr   = front_dec;
        end
      end
      dqls_pkg::OP_PUSH_BACK: begin
        if (full) start_status = dqls_pkg::ST_FULL;
        else begin
          count_nxt = count_r + CW'(1);
          wr_en     = 1'b1;
        end
      end
      dqls_pkg::OP_POP_FRONT: begin
        if (empty) start_status = dqls_pkg::ST_EMPTY;
        else begin
          front_nxt = front_inc;
          count_nxt = count_r - CW'(1);
        end
      end
      dqls_pkg::OP_POP_BACK: begin
        if (empty) start_status = dqls_pkg::ST_EMPTY;
        else count_nxt = count_r - CW'(1);
      end
      default: ;
    endcase
  end

  assign rd_addr = cmd.start ? front_r : next_addr_r;

  always_ff @(posedge clk) begin
    if (cmd.start && wr_en) mem[wr_addr] <= item_value;
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else if (cmd.start) begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r        <= search_key;
      next_addr_r  <= front_inc;
      cmp_off_r    <= '0;
      res_status_r <= start_status;
      res_found_r  <= 1'b0;
      res_pos_r    <= '0;
    end else if (cmd.step) begin
      next_addr_r <= next_inc;
      cmp_off_r   <= cmp_off_r + AW'(1);
      if (stat.hit) begin
        res_found_r <= 1'b1;
        res_pos_r   <= cmp_off_r;
      end
    end
  end

  assign pos_ext = 32'(res_pos_r);
  assign cnt_ext = 32'(count_r);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= {7'd0, empty, cnt_ext[dqls_pkg::COUNT_W-1:0],
                   pos_ext[dqls_pkg::POS_W-1:0], res_found_r, res_status_r};
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_step_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !empty)
    else $error("search step on empty queue");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start && !full && (func == dqls_pkg::OP_PUSH_FRONT || func == dqls_pkg::OP_PUSH_BACK)
    |=> count_r == $past(count_r) + CW'(1))
    else $error("push did not grow count");

  a_search_static: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> front_r == $past(front_r) && count_r == $past(count_r))
    else $error("queue state moved during search");
`endif

endmodule
`default_nettype wire

// ===== src/deque_with_linear_search_core.sv =====
// Deque of signed 32-bit words in a ring store with front-to-back search.
// Channels: in_* carries one operation per word: in_tuser[2:0] = func,
//   in_tdata[31:0] = item_value, in_tdata[63:32] = search_key.
// out_* carries one result word per operation: out_tdata[1:0] status,
//   [2] found, [8:3] match_position, [15:9] entry_count, [16] is_empty.
// Inserts, erases and undefined codes pass through S_DONE, where the result
// is loaded into the output register, and such words stream at one per
// cycle while the receiver takes results. A search walks the ring store one
// entry per cycle through its single registered read port, stopping at the
// first match or the back entry; no new word is taken until it ends.
// If the receiver stalls, the finished result stays in the output
// register; one more word is accepted and executed, then in_tready drops
// until the output is taken. Reset (rst_n low, synchronous) empties the
// queue and clears the output valid; store contents are not cleared.
// Depends on dqls_pkg, dqls_ctrl and dqls_datapath.
`default_nettype none
module deque_with_linear_search_core #(
  parameter int DEPTH = dqls_pkg::DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // item_value, search_key
  input  wire logic [dqls_pkg::IN_DATA_W-1:0]    in_tdata,
  // func
  input  wire logic [dqls_pkg::FUNC_W-1:0]       in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // status, found, match_position, entry_count, is_empty, zero pad
  output logic [dqls_pkg::OUT_DATA_W-1:0]        out_tdata
);

  dqls_pkg::dqls_cmd_t  cmd;
  dqls_pkg::dqls_stat_t stat;

  dqls_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .func       (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  dqls_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .func       (in_tuser),
    .item_value (in_tdata[31:0]),
    .search_key (in_tdata[63:32]),
    .stat       (stat),
    .out_data   (out_tdata)
  );

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for deque_with_linear_search_core: a ring-store deque model
// predicts each result word; directed, fill/drain, drain-pause and random traffic under varied stalls.
// Depends on dqls_pkg and the core RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH  = dqls_pkg::DEPTH_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 320;

  typedef struct packed {
    logic [dqls_pkg::STATUS_W-1:0] status;
    logic                          found;
    logic [dqls_pkg::POS_W-1:0]    position;
    logic [dqls_pkg::COUNT_W-1:0]  count;
    logic                          empty;
  } dq_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [dqls_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [dqls_pkg::FUNC_W-1:0]     in_tuser = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [dqls_pkg::OUT_DATA_W-1:0] out_tdata;

  // deque model state
  logic [dqls_pkg::VALUE_W-1:0] ring_mem [RING_DEPTH];
  int                           ring_front = 0;
  int                           ring_count = 0;

  dq_result_t expected_results [$];
  int         error_count = 0;
  int         cycle_count = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;

  deque_with_linear_search_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic dq_result_t deque_apply(logic [dqls_pkg::FUNC_W-1:0] func,
                                             logic [dqls_pkg::VALUE_W-1:0] value,
                                             logic [dqls_pkg::VALUE_W-1:0] key);
    dq_result_t res;
    res = '0;
    res.status = dqls_pkg::ST_DONE;
    case (func)
      dqls_pkg::OP_PUSH_FRONT: begin
        if (ring_count >= RING_DEPTH) res.status = dqls_pkg::ST_FULL;
        else begin
          ring_front = (ring_front + RING_DEPTH - 1) % RING_DEPTH;
          ring_mem[ring_front] = value;
          ring_count++;
        end
      end
      dqls_pkg::OP_PUSH_BACK: begin
        if (ring_count >= RING_DEPTH) res.status = dqls_pkg::ST_FULL;
        else begin
          ring_mem[(ring_front + ring_count) % RING_DEPTH] = value;
          ring_count++;
        end
      end
      dqls_pkg::OP_POP_FRONT: begin
        if (ring_count == 0) res.status = dqls_pkg::ST_EMPTY;
        else begin
          ring_front = (ring_front + 1) % RING_DEPTH;
          ring_count--;
        end
      end
      dqls_pkg::OP_POP_BACK: begin
        if (ring_count == 0) res.status = dqls_pkg::ST_EMPTY;
        else ring_count--;
      end
      dqls_pkg::OP_SEARCH: begin
        for (int i = 0; i < ring_count; i++) begin
          if (ring_mem[(ring_front + i) % RING_DEPTH] == key) begin
            res.found = 1'b1;
            res.position = dqls_pkg::POS_W'(i);
            break;
          end
        end
      end
      default: ;
    endcase
    res.count = dqls_pkg::COUNT_W'(ring_count);
    res.empty = (ring_count == 0);
    return res;
  endfunction

  task automatic send_op(logic [dqls_pkg::FUNC_W-1:0] func,
                         logic [dqls_pkg::VALUE_W-1:0] value,
                         logic [dqls_pkg::VALUE_W-1:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {key, value};
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(deque_apply(func, value, key));
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [dqls_pkg::VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(5);
    case (r)
      0, 1: return dqls_pkg::VALUE_W'($urandom_range(15)) - 32'd8;
      2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [dqls_pkg::VALUE_W-1:0] pick_key();
    int r;
    r = $urandom_range(9);
    if (ring_count > 0 && r < 6)
      return ring_mem[(ring_front + $urandom_range(ring_count - 1)) % RING_DEPTH];
    if (r < 8) return pick_value();
    return $urandom;
  endfunction

  task automatic test_directed();
    send_op(dqls_pkg::OP_SEARCH, $urandom, 32'h0000_0000);
    send_op(dqls_pkg::OP_POP_FRONT, $urandom, $urandom);
    send_op(dqls_pkg::OP_POP_BACK, $urandom, $urandom);
    send_op(dqls_pkg::OP_PUSH_BACK, 32'h7fff_ffff, $urandom);
    send_op(dqls_pkg::OP_PUSH_FRONT, 32'h8000_0000, $urandom);
    send_op(dqls_pkg::OP_PUSH_BACK, 32'h0000_0000, $urandom);
    send_op(dqls_pkg::OP_PUSH_FRONT, 32'hffff_ffff, $urandom);
    send_op(dqls_pkg::OP_SEARCH, $urandom, 32'h7fff_ffff);
    send_op(dqls_pkg::OP_SEARCH, $urandom, 32'h0000_0000);
    send_op(dqls_pkg::OP_SEARCH, $urandom, 32'hffff_ffff);
    send_op(dqls_pkg::OP_SEARCH, $urandom, 32'h0001_2345);
    send_op(dqls_pkg::OP_PUSH_BACK, 32'h8000_0000, $urandom);
    send_op(dqls_pkg::OP_SEARCH, $urandom, 32'h8000_0000);
    send_op(3'd5, $urandom, $urandom);
    send_op(3'd6, $urandom, $urandom);
    send_op(3'd7, 32'hffff_ffff, 32'hffff_ffff);
    send_op(dqls_pkg::OP_POP_FRONT, $urandom, $urandom);
    send_op(dqls_pkg::OP_POP_BACK, $urandom, $urandom);
    send_op(dqls_pkg::OP_SEARCH, $urandom, 32'h8000_0000);
    send_op(dqls_pkg::OP_POP_BACK, $urandom, $urandom);
    send_op(dqls_pkg::OP_POP_FRONT, $urandom, $urandom);
    send_op(dqls_pkg::OP_POP_BACK, $urandom, $urandom);
    send_op(dqls_pkg::OP_SEARCH, $urandom, 32'h7fff_ffff);
  endtask

  // fill to full, overflow, search the deepest entry, drain past empty
  task automatic test_fill_drain();
    while (ring_count < RING_DEPTH)
      send_op($urandom_range(1) ? dqls_pkg::OP_PUSH_FRONT : dqls_pkg::OP_PUSH_BACK,
              pick_value(), $urandom);
    repeat (3)
      send_op($urandom_range(1) ? dqls_pkg::OP_PUSH_FRONT : dqls_pkg::OP_PUSH_BACK,
              $urandom, $urandom);
    send_op(dqls_pkg::OP_SEARCH, $urandom,
            ring_mem[(ring_front + RING_DEPTH - 1) % RING_DEPTH]);
    send_op(dqls_pkg::OP_SEARCH, $urandom, $urandom);
    send_op(dqls_pkg::OP_SEARCH, $urandom, pick_key());
    while (ring_count > 0)
      send_op($urandom_range(1) ? dqls_pkg::OP_POP_FRONT : dqls_pkg::OP_POP_BACK,
              $urandom, $urandom);
    send_op(dqls_pkg::OP_POP_FRONT, $urandom, $urandom);
    send_op(dqls_pkg::OP_POP_BACK, $urandom, $urandom);
    send_op(dqls_pkg::OP_SEARCH, $urandom, $urandom);
  endtask

  // sender stops until every result is back, then resumes
  task automatic test_drain_pause();
    repeat (3) begin
      repeat (8)
        send_op($urandom_range(1) ? dqls_pkg::OP_PUSH_BACK : dqls_pkg::OP_PUSH_FRONT,
                pick_value(), $urandom);
      send_op(dqls_pkg::OP_SEARCH, $urandom, pick_key());
      hold_until_drained();
    end
  endtask

  task automatic test_random_traffic(int n, int send_pct, int recv_pct);
    int push_bias;
    int r;
    logic [dqls_pkg::FUNC_W-1:0] func;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    push_bias = 50;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) begin
        r = $urandom_range(2);
        push_bias = (r == 0) ? 85 : (r == 1) ? 50 : 15;
      end
      r = $urandom_range(99);
      if (r < 4) func = dqls_pkg::FUNC_W'($urandom_range(7, 5));
      else if (r < 34) func = dqls_pkg::OP_SEARCH;
      else if ($urandom_range(99) < push_bias)
        func = $urandom_range(1) ? dqls_pkg::OP_PUSH_FRONT : dqls_pkg::OP_PUSH_BACK;
      else func = $urandom_range(1) ? dqls_pkg::OP_POP_FRONT : dqls_pkg::OP_POP_BACK;
      send_op(func, pick_value(), (func == dqls_pkg::OP_SEARCH) ? pick_key() : $urandom);
    end
  endtask

  initial begin
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    dq_result_t want;
    dq_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[1:0], out_tdata[2], out_tdata[8:3], out_tdata[15:9], out_tdata[16]};
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result word %h", $time, out_tdata);
      end else begin
        want = expected_results.pop_front();
        if (got !== want || out_tdata[dqls_pkg::OUT_DATA_W-1:17] !== '0) begin
          error_count++;
          $display("%0t: mismatch exp st=%0d f=%0d pos=%0d cnt=%0d e=%0d act %h",
                   $time, want.status, want.found, want.position, want.count,
                   want.empty, out_tdata);
        end
      end
    end
  end

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 18;
    recv_idle_pct = 71;
    test_directed();
    test_fill_drain();
    test_drain_pause();
    test_random_traffic(RANDOM_ITEMS, 18, 71);
    test_random_traffic(RANDOM_ITEMS, 71, 18);
    test_drain_pause();
    test_random_traffic(RANDOM_ITEMS, 0, 0);
    hold_until_drained();
    repeat (80) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
